// ===== src/mnpt_pkg.sv =====
package mnpt_pkg;

  // Field widths fixed by the item format.
  localparam int COORD_W = 48;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DIST_W  = COORD_W + 2;
  localparam int OIDX_W  = 10;
  localparam int STAT_W  = 2;

  // Default table depth.
  localparam int MAX_POINTS_DEF = 1024;

  // Command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Control that travels alongside a point through the distance pipeline.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mnpt_tag_t;

endpackage

// ===== src/mnpt_if.sv =====
interface mnpt_in_if;
  import mnpt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, cmd, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, cmd, coord_x, coord_y, coord_z, output ready);
endinterface

interface mnpt_out_if;
  import mnpt_pkg::*;

  logic              valid;
  logic              ready;
  logic [OIDX_W-1:0] nearest_index;
  logic [STAT_W-1:0] status;

  modport source (output valid, nearest_index, status, input ready);
  modport sink (input valid, nearest_index, status, output ready);
endinterface

// ===== src/manhattan_nearest_point_table.sv =====
// Add item, and find on an empty table: the result is registered in the next cycle,
// and the next item can be taken once the output register is free.
// Find item: the scan reads one stored point per cycle from the point memory and feeds it
// through a four-stage distance and compare pipeline. After the last point, the block
// waits in the finish state for a free output register, loads the result and goes idle.
// Reset clears the count, the state and the valid flags; the point memory is not cleared.
module manhattan_nearest_point_table #(
  parameter int MAX_POINTS = mnpt_pkg::MAX_POINTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mnpt_in_if.sink   in_item,
  mnpt_out_if.source out_item
);
  import mnpt_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int MW = 3 * COORD_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r;
  logic [IW-1:0]             scan_idx_r, last_idx_r, cmp_idx_r, best_idx_r;
  logic                      issue_r;
  logic [DIST_W-1:0]         best_r;
  logic signed [COORD_W-1:0] q_x_r, q_y_r, q_z_r;

  logic                      out_valid_r;
  logic [OIDX_W-1:0]         out_idx_r;
  logic [STAT_W-1:0]         out_stat_r;

  logic [MW-1:0]             mem [MAX_POINTS];
  logic [MW-1:0]             rdata_r;
  mnpt_tag_t                 rd_tag_r, dist_tag;
  logic [DIST_W-1:0]         distance;

  logic                      out_free, in_acc, full, empty, rd_en, load_out;
  logic [OIDX_W-1:0]         load_idx;
  logic [STAT_W-1:0]         load_stat;
  logic [IW+OIDX_W-1:0]      wr_idx_ext, best_idx_ext;

  assign out_free = !out_valid_r || out_item.ready;
  assign in_acc   = in_item.valid && in_item.ready;
  assign full     = (count_r == CW'(MAX_POINTS));
  assign empty    = (count_r == '0);
  assign rd_en    = (state_r == S_SCAN) && issue_r;

  // Index reported to the user is the low ten bits of the table index.
  assign wr_idx_ext   = {{OIDX_W{1'b0}}, count_r[IW-1:0]};
  assign best_idx_ext = {{OIDX_W{1'b0}}, best_idx_r};

  assign in_item.ready = (state_r == S_IDLE) && out_free;

  // Next state and the result to load into the output register.
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    load_idx  = '0;
    load_stat = STAT_OK;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.cmd == CMD_ADD) begin
            load_out = 1'b1;
            if (full) begin
              load_stat = STAT_FULL;
            end else begin
              load_idx = wr_idx_ext[OIDX_W-1:0];
            end
          end else if (empty) begin
            load_out  = 1'b1;
            load_stat = STAT_EMPTY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_idx  = best_idx_ext[OIDX_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers: state, point count, issue flag, output valid and read tag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rd_tag_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_item.cmd == CMD_ADD && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == S_IDLE && in_acc && in_item.cmd == CMD_FIND && !empty) begin
        issue_r <= 1'b1;
      end else if (rd_en && scan_idx_r == last_idx_r) begin
        issue_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      rd_tag_r.vld   <= rd_en;
      rd_tag_r.first <= rd_en && (scan_idx_r == '0);
      rd_tag_r.last  <= rd_en && (scan_idx_r == last_idx_r);
    end
  end

  // Query capture and scan address.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_item.cmd == CMD_FIND) begin
      q_x_r      <= in_item.coord_x;
      q_y_r      <= in_item.coord_y;
      q_z_r      <= in_item.coord_z;
      last_idx_r <= IW'(count_r - CW'(1));
      scan_idx_r <= '0;
    end else if (rd_en) begin
      scan_idx_r <= scan_idx_r + IW'(1);
    end
  end

  // Point memory: one write port for adds, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (in_acc && in_item.cmd == CMD_ADD && !full) begin
      mem[count_r[IW-1:0]] <= {in_item.coord_x, in_item.coord_y, in_item.coord_z};
    end
    if (rd_en) begin
      rdata_r <= mem[scan_idx_r];
    end
  end

  // Distance pipeline for the scan.
  mnpt_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (rd_tag_r),
    .pt_x     (rdata_r[3*COORD_W-1:2*COORD_W]),
    .pt_y     (rdata_r[2*COORD_W-1:COORD_W]),
    .pt_z     (rdata_r[COORD_W-1:0]),
    .q_x      (q_x_r),
    .q_y      (q_y_r),
    .q_z      (q_z_r),
    .tag_out  (dist_tag),
    .distance (distance)
  );

  // Running minimum; a strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (dist_tag.vld) begin
      if (dist_tag.first) begin
        best_r     <= distance;
        best_idx_r <= '0;
        cmp_idx_r  <= IW'(1);
      end else begin
        if (distance < best_r) begin
          best_r     <= distance;
          best_idx_r <= cmp_idx_r;
        end
        cmp_idx_r <= cmp_idx_r + IW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r  <= load_idx;
      out_stat_r <= load_stat;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.nearest_index = out_idx_r;
  assign out_item.status        = out_stat_r;

endmodule

// ===== src/mnpt_dist.sv =====
module mnpt_dist (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mnpt_pkg::mnpt_tag_t                tag_in,
  input  logic signed [mnpt_pkg::COORD_W-1:0] pt_x,
  input  logic signed [mnpt_pkg::COORD_W-1:0] pt_y,
  input  logic signed [mnpt_pkg::COORD_W-1:0] pt_z,
  input  logic signed [mnpt_pkg::COORD_W-1:0] q_x,
  input  logic signed [mnpt_pkg::COORD_W-1:0] q_y,
  input  logic signed [mnpt_pkg::COORD_W-1:0] q_z,
  output mnpt_pkg::mnpt_tag_t                tag_out,
  output logic [mnpt_pkg::DIST_W-1:0]        distance
);
  import mnpt_pkg::*;

  mnpt_tag_t                tag1_r, tag2_r, tag3_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic [COORD_W-1:0]       ax_r, ay_r, az_r;
  logic [DIST_W-1:0]        sum_r;

  // Stage one: signed differences, one bit wider than a coordinate.
  // Stage two: magnitudes, which always fit in a coordinate's width.
  // Stage three: the Manhattan sum.
  always_ff @(posedge clk) begin
    dx_r  <= DIFF_W'(pt_x) - DIFF_W'(q_x);
    dy_r  <= DIFF_W'(pt_y) - DIFF_W'(q_y);
    dz_r  <= DIFF_W'(pt_z) - DIFF_W'(q_z);
    ax_r  <= dx_r[DIFF_W-1] ? COORD_W'(-dx_r) : COORD_W'(dx_r);
    ay_r  <= dy_r[DIFF_W-1] ? COORD_W'(-dy_r) : COORD_W'(dy_r);
    az_r  <= dz_r[DIFF_W-1] ? COORD_W'(-dz_r) : COORD_W'(dz_r);
    sum_r <= DIST_W'(ax_r) + DIST_W'(ay_r) + DIST_W'(az_r);
  end

  // Control flags follow the data through the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  assign tag_out  = tag3_r;
  assign distance = sum_r;

endmodule
